### sv/pfi_pkg.sv
package pfi_pkg;

  // Fixed field widths
  localparam int COEF_W     = 16;
  localparam int IFW        = 5;   // interp_factor
  localparam int TCW        = 6;   // tap_count
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 6;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_INTERP = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TAPS   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TRIM   = 2'd2;

  // Input item operation codes
  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_COEF   = 1'b1;

  typedef struct packed {
    logic coef_wr;
    logic hist_shift;
    logic hist_clr;
    logic acc_clr;
    logic term_valid;
    logic emit;
    logic emit_lor;
    logic emit_eob;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } sts_t;

endpackage

### sv/pfi_ram.sv
module pfi_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### sv/pfi_datapath.sv
module pfi_datapath #(
  parameter int MAX_TAPS     = 32,
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic                                            clk_i,
  input  logic                                            rst_ni,
  input  pfi_pkg::cmd_t                                   cmd_i,
  output pfi_pkg::sts_t                                   sts_o,
  input  logic [$clog2(MAX_TAPS)-1:0]                     coef_raddr_i,
  input  logic [$clog2(MAX_TAPS)-1:0]                     hist_idx_i,
  input  logic signed [SAMPLE_WIDTH-1:0]                  sample_in_i,
  input  logic [$clog2(MAX_TAPS)-1:0]                     coef_index_i,
  input  logic signed [pfi_pkg::COEF_W-1:0]               coef_value_i,
  input  logic                                            out_stall_i,
  output logic                                            out_valid_o,
  output logic signed [SAMPLE_WIDTH+pfi_pkg::COEF_W+$clog2(MAX_TAPS)-1:0] filtered_value_o,
  output logic                                            last_of_run_o,
  output logic                                            end_of_block_o
);

  localparam int AW   = $clog2(MAX_TAPS);
  localparam int PW   = SAMPLE_WIDTH + pfi_pkg::COEF_W;
  localparam int ACCW = PW + AW;

  logic signed [SAMPLE_WIDTH-1:0]    hist_q [MAX_TAPS];
  logic signed [SAMPLE_WIDTH-1:0]    hist_rd_q;
  logic signed [pfi_pkg::COEF_W-1:0] coef_rd;
  logic signed [PW-1:0]              prod_q;
  logic signed [ACCW-1:0]            acc_q;
  logic                              v1_q, v2_q;
  logic                              out_valid_q;
  logic signed [ACCW-1:0]            out_val_q;
  logic                              out_lor_q, out_eob_q;
  logic                              coef_we;

  assign coef_we = cmd_i.coef_wr && (32'(coef_index_i) < 32'(MAX_TAPS));

  pfi_ram #(
    .WIDTH (pfi_pkg::COEF_W),
    .DEPTH (MAX_TAPS)
  ) u_coef_ram (
    .clk_i   (clk_i),
    .we_i    (coef_we),
    .waddr_i (coef_index_i),
    .wdata_i (coef_value_i),
    .raddr_i (coef_raddr_i),
    .rdata_o (coef_rd)
  );

  // Delay line, newest sample at entry 0
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < MAX_TAPS; k++) hist_q[k] <= '0;
    end else if (cmd_i.hist_clr) begin
      for (int k = 0; k < MAX_TAPS; k++) hist_q[k] <= '0;
    end else if (cmd_i.hist_shift) begin
      hist_q[0] <= sample_in_i;
      for (int k = 1; k < MAX_TAPS; k++) hist_q[k] <= hist_q[k-1];
    end
  end

  // MAC pipeline: read, multiply, accumulate
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= cmd_i.term_valid;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    hist_rd_q <= hist_q[hist_idx_i];
    prod_q    <= PW'(coef_rd) * PW'(hist_rd_q);
    if (cmd_i.acc_clr) begin
      acc_q <= '0;
    end else if (v2_q) begin
      acc_q <= acc_q + ACCW'(prod_q);
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_val_q <= acc_q;
      out_lor_q <= cmd_i.emit_lor;
      out_eob_q <= cmd_i.emit_eob;
    end
  end

  assign sts_o.out_free  = !out_valid_q || !out_stall_i;
  assign out_valid_o      = out_valid_q;
  assign filtered_value_o = out_val_q;
  assign last_of_run_o    = out_lor_q;
  assign end_of_block_o   = out_eob_q;

endmodule

### sv/pfi_ctrl.sv
module pfi_ctrl #(
  parameter int MAX_TAPS   = 32,
  parameter int MAX_INTERP = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  input  logic                             operation_i,
  input  logic                             last_sample_i,
  output logic                             in_stall_o,
  input  logic                             cfg_wr_en_i,
  input  logic [pfi_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [pfi_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  output pfi_pkg::cmd_t                    cmd_o,
  input  pfi_pkg::sts_t                    sts_i,
  output logic [$clog2(MAX_TAPS)-1:0]      coef_raddr_o,
  output logic [$clog2(MAX_TAPS)-1:0]      hist_idx_o
);

  localparam int AW  = $clog2(MAX_TAPS);
  localparam int LFW = $clog2(MAX_INTERP + 1);
  localparam int NTW = $clog2(MAX_TAPS + 1);
  localparam int QW  = $clog2(MAX_INTERP + MAX_TAPS + 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_START,
    ST_ISSUE,
    ST_DRAIN,
    ST_EMIT
  } state_e;

  state_e                 state_q, state_d;
  logic [pfi_pkg::IFW-1:0] cfg_lf_q;
  logic [pfi_pkg::TCW-1:0] cfg_nt_q;
  logic                   cfg_trim_q;

  logic [LFW-1:0] lf_q, lf_d, lf_c;
  logic [NTW-1:0] nt_q, nt_d, nt_c;
  logic           trim_q, trim_d, last_q, last_d;
  logic [QW-1:0]  cand_q, cand_d, q_q, q_d, idx_q, idx_d;
  logic [AW-1:0]  j_q, j_d;
  logic [NTW-1:0] drop_q, drop_d;

  logic [NTW-1:0] lat_c, rem_c;
  logic [QW-1:0]  cand_c, skip_c;
  logic           accept;

  assign accept = in_valid_i && (state_q == ST_IDLE);

  always_comb begin
    if (cfg_lf_q == '0) begin
      lf_c = LFW'(1);
    end else if (32'(cfg_lf_q) > 32'(MAX_INTERP)) begin
      lf_c = LFW'(MAX_INTERP);
    end else begin
      lf_c = LFW'(cfg_lf_q);
    end
    if (cfg_nt_q == '0) begin
      nt_c = NTW'(1);
    end else if (32'(cfg_nt_q) > 32'(MAX_TAPS)) begin
      nt_c = NTW'(MAX_TAPS);
    end else begin
      nt_c = NTW'(cfg_nt_q);
    end
  end

  // Per-item schedule: candidate output count and how many leading outputs trimmed mode drops
  always_comb begin
    lat_c = (nt_q - NTW'(1)) >> 1;
    if (!last_q) begin
      cand_c = QW'(lf_q);
    end else if (trim_q) begin
      cand_c = QW'(lf_q) + QW'(lat_c);
    end else begin
      cand_c = QW'(nt_q);
    end
    rem_c = (drop_q < lat_c) ? (lat_c - drop_q) : '0;
    if (!trim_q) begin
      skip_c = '0;
    end else if (QW'(rem_c) < cand_c) begin
      skip_c = QW'(rem_c);
    end else begin
      skip_c = cand_c;
    end
  end

  always_comb begin
    state_d = state_q;
    lf_d    = lf_q;
    nt_d    = nt_q;
    trim_d  = trim_q;
    last_d  = last_q;
    cand_d  = cand_q;
    q_d     = q_q;
    idx_d   = idx_q;
    j_d     = j_q;
    drop_d  = drop_q;
    cmd_o   = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (operation_i == pfi_pkg::OP_COEF) begin
            cmd_o.coef_wr = 1'b1;
          end else begin
            cmd_o.hist_shift = 1'b1;
            lf_d    = lf_c;
            nt_d    = nt_c;
            trim_d  = cfg_trim_q;
            last_d  = last_sample_i;
            state_d = ST_SETUP;
          end
        end
      end
      ST_SETUP: begin
        cand_d  = cand_c;
        q_d     = skip_c;
        drop_d  = drop_q + NTW'(skip_c);
        state_d = ST_START;
      end
      ST_START: begin
        if (q_q >= cand_q) begin
          if (last_q) begin
            cmd_o.hist_clr = 1'b1;
            drop_d = '0;
          end
          state_d = ST_IDLE;
        end else begin
          cmd_o.acc_clr = 1'b1;
          idx_d   = q_q;
          j_d     = '0;
          state_d = ST_ISSUE;
        end
      end
      ST_ISSUE: begin
        if (idx_q < QW'(nt_q)) begin
          cmd_o.term_valid = 1'b1;
          idx_d = idx_q + QW'(lf_q);
          j_d   = j_q + AW'(1);
        end else begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        // last product reaches the accumulator at the end of this cycle
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit     = 1'b1;
          cmd_o.emit_lor = (q_q == cand_q - QW'(1));
          cmd_o.emit_eob = (q_q == cand_q - QW'(1)) && last_q;
          q_d     = q_q + QW'(1);
          state_d = ST_START;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      cfg_lf_q   <= pfi_pkg::IFW'(1);
      cfg_nt_q   <= pfi_pkg::TCW'(1);
      cfg_trim_q <= 1'b0;
      lf_q       <= LFW'(1);
      nt_q       <= NTW'(1);
      trim_q     <= 1'b0;
      last_q     <= 1'b0;
      cand_q     <= '0;
      q_q        <= '0;
      idx_q      <= '0;
      j_q        <= '0;
      drop_q     <= '0;
    end else begin
      state_q <= state_d;
      lf_q    <= lf_d;
      nt_q    <= nt_d;
      trim_q  <= trim_d;
      last_q  <= last_d;
      cand_q  <= cand_d;
      q_q     <= q_d;
      idx_q   <= idx_d;
      j_q     <= j_d;
      drop_q  <= drop_d;
      if (cfg_wr_en_i) begin
        unique case (cfg_index_i)
          pfi_pkg::CFG_INTERP: cfg_lf_q   <= cfg_data_i[pfi_pkg::IFW-1:0];
          pfi_pkg::CFG_TAPS:   cfg_nt_q   <= cfg_data_i[pfi_pkg::TCW-1:0];
          pfi_pkg::CFG_TRIM:   cfg_trim_q <= cfg_data_i[0];
          default: ;
        endcase
      end
    end
  end

  assign in_stall_o   = (state_q != ST_IDLE);
  assign coef_raddr_o = AW'(idx_q);
  assign hist_idx_o   = j_q;

endmodule

### sv/polyphase_fir_interpolator.sv
// Channel  Direction  Handshake                 Payload
// in       input      in_valid_i / in_stall_o   operation, sample_in, last_sample, coef_index,
//                                               coef_value
// out      output     out_valid_o / out_stall_i filtered_value, last_of_run, end_of_block
// cfg      input      cfg_wr_en_i               cfg_index_i, cfg_data_i
//
// A coefficient write does not raise in_stall_o. A sample holds in_stall_o while its results
// are worked out and handed over; dropped results cost no work. An ordinary sample in full mode
// needs nT tap products in all: one shared multiplier does one tap product per cycle, and each
// result adds a setup, issue end, drain and transfer step.
// Reset clears the delay line, the trim count, the control registers and out_valid_o; the tap store is not cleared.
// A stall on the output holds the result register; the sequencer waits in its emit step.
module polyphase_fir_interpolator #(
  parameter int MAX_TAPS     = 32,
  parameter int MAX_INTERP   = 16,
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic                                 operation_i,
  input  logic signed [SAMPLE_WIDTH-1:0]       sample_in_i,
  input  logic                                 last_sample_i,
  input  logic [$clog2(MAX_TAPS)-1:0]          coef_index_i,
  input  logic signed [pfi_pkg::COEF_W-1:0]    coef_value_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic signed [SAMPLE_WIDTH+pfi_pkg::COEF_W+$clog2(MAX_TAPS)-1:0] filtered_value_o,
  output logic                                 last_of_run_o,
  output logic                                 end_of_block_o,
  input  logic                                 cfg_wr_en_i,
  input  logic [pfi_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [pfi_pkg::CFG_DATA_W-1:0]       cfg_data_i
);

  localparam int AW = $clog2(MAX_TAPS);

  pfi_pkg::cmd_t cmd;
  pfi_pkg::sts_t sts;
  logic [AW-1:0] coef_raddr;
  logic [AW-1:0] hist_idx;

  pfi_ctrl #(
    .MAX_TAPS   (MAX_TAPS),
    .MAX_INTERP (MAX_INTERP)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .operation_i   (operation_i),
    .last_sample_i (last_sample_i),
    .in_stall_o    (in_stall_o),
    .cfg_wr_en_i   (cfg_wr_en_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .cmd_o         (cmd),
    .sts_i         (sts),
    .coef_raddr_o  (coef_raddr),
    .hist_idx_o    (hist_idx)
  );

  pfi_datapath #(
    .MAX_TAPS     (MAX_TAPS),
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .coef_raddr_i     (coef_raddr),
    .hist_idx_i       (hist_idx),
    .sample_in_i      (sample_in_i),
    .coef_index_i     (coef_index_i),
    .coef_value_i     (coef_value_i),
    .out_stall_i      (out_stall_i),
    .out_valid_o      (out_valid_o),
    .filtered_value_o (filtered_value_o),
    .last_of_run_o    (last_of_run_o),
    .end_of_block_o   (end_of_block_o)
  );

endmodule

### sv/pfi_checker.sv
module pfi_props #(
  parameter int MAX_TAPS     = 32,
  parameter int MAX_INTERP   = 16,
  parameter int SAMPLE_WIDTH = 16
) (
  input logic                                 clk_i,
  input logic                                 rst_ni,
  input logic                                 in_valid_i,
  input logic                                 in_stall_o,
  input logic                                 operation_i,
  input logic signed [SAMPLE_WIDTH-1:0]       sample_in_i,
  input logic                                 last_sample_i,
  input logic [$clog2(MAX_TAPS)-1:0]          coef_index_i,
  input logic signed [pfi_pkg::COEF_W-1:0]    coef_value_i,
  input logic                                 out_valid_o,
  input logic                                 out_stall_i,
  input logic signed [SAMPLE_WIDTH+pfi_pkg::COEF_W+$clog2(MAX_TAPS)-1:0] filtered_value_o,
  input logic                                 last_of_run_o,
  input logic                                 end_of_block_o,
  input logic                                 cfg_wr_en_i,
  input logic [pfi_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input logic [pfi_pkg::CFG_DATA_W-1:0]       cfg_data_i
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(filtered_value_o)
      && $stable(last_of_run_o) && $stable(end_of_block_o))
    else $error("stalled result changed");

  // a sample transfer starts the sequencer
  a_sample_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && (operation_i == pfi_pkg::OP_SAMPLE) |=> in_stall_o)
    else $error("sample transfer did not start work");

  // a coefficient write does not stall the input
  a_coef_quick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && (operation_i == pfi_pkg::OP_COEF) |=> !in_stall_o)
    else $error("coefficient write held the input");

  a_eob_lor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && end_of_block_o |-> last_of_run_o)
    else $error("end of block without last of run");

  // results come only from a sample in progress
  a_out_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result appeared while idle");

endmodule

bind polyphase_fir_interpolator pfi_props #(
  .MAX_TAPS     (MAX_TAPS),
  .MAX_INTERP   (MAX_INTERP),
  .SAMPLE_WIDTH (SAMPLE_WIDTH)
) u_pfi_props (.*);
